>>> rtl/core/mfd_pkg.sv
package mfd_pkg;

   localparam int unsigned ByteWidth = 8;

   localparam logic [ByteWidth-1:0] CHAR_I = 8'h49;
   localparam logic [ByteWidth-1:0] CHAR_M = 8'h4d;
   localparam logic [ByteWidth-1:0] CHAR_P = 8'h50;
   localparam logic [ByteWidth-1:0] CHAR_R = 8'h52;
   localparam logic [ByteWidth-1:0] CHAR_O = 8'h4f;
   localparam logic [ByteWidth-1:0] CHAR_V = 8'h56;

   localparam logic [ByteWidth-1:0] VERSION_RESET = 8'h01;

   localparam int unsigned RspDataWidth = 4 * ByteWidth;

   typedef enum logic [10:0] {
      ST_HUNT0   = 11'b000_0000_0001,
      ST_HUNT1   = 11'b000_0000_0010,
      ST_HUNT2   = 11'b000_0000_0100,
      ST_HUNT3   = 11'b000_0000_1000,
      ST_HUNT4   = 11'b000_0001_0000,
      ST_HUNT5   = 11'b000_0010_0000,
      ST_VERSION = 11'b000_0100_0000,
      ST_TYPE    = 11'b000_1000_0000,
      ST_LENGTH  = 11'b001_0000_0000,
      ST_PAYLOAD = 11'b010_0000_0000,
      ST_CHECK   = 11'b100_0000_0000
   } mfd_state_type;

   typedef struct packed {
      logic                 is_end;
      logic [ByteWidth-1:0] frame_type;
      logic [ByteWidth-1:0] payload_byte;
      logic [ByteWidth-1:0] payload_index;
      logic                 checksum_ok;
      logic [ByteWidth-1:0] payload_length;
   } mfd_result_type;

endpackage

>>> rtl/core/mfd_parser.sv
module mfd_parser
   import mfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [ByteWidth-1:0] rx_byte,
   input  logic [ByteWidth-1:0] expected_version,
   output logic                 res_vld,
   output mfd_result_type       res
);

   mfd_state_type        state_ff, state_in;
   logic [ByteWidth-1:0] type_ff, type_in;
   logic [ByteWidth-1:0] length_ff, length_in;
   logic [ByteWidth-1:0] remain_ff, remain_in;
   logic [ByteWidth-1:0] sum_ff, sum_in;
   logic [ByteWidth-1:0] sum_add;
   logic                 is_i;

   assign sum_add = sum_ff + rx_byte;
   assign is_i    = (rx_byte == CHAR_I);

   always_comb begin
      state_in  = state_ff;
      type_in   = type_ff;
      length_in = length_ff;
      remain_in = remain_ff;
      sum_in    = sum_ff;
      res_vld   = 1'b0;
      res       = '0;
      res.frame_type     = type_ff;
      res.payload_length = length_ff;
      // mismatch default: a stray 'I' may open a new marker
      if (is_i) begin
         state_in = ST_HUNT1;
         sum_in   = rx_byte;
      end else begin
         state_in = ST_HUNT0;
         sum_in   = '0;
      end
      unique case (state_ff)
         ST_HUNT0: begin
         end
         ST_HUNT1: begin
            if (rx_byte == CHAR_M) begin
               state_in = ST_HUNT2;
               sum_in   = sum_add;
            end
         end
         ST_HUNT2: begin
            if (rx_byte == CHAR_P) begin
               state_in = ST_HUNT3;
               sum_in   = sum_add;
            end
         end
         ST_HUNT3: begin
            if (rx_byte == CHAR_R) begin
               state_in = ST_HUNT4;
               sum_in   = sum_add;
            end
         end
         ST_HUNT4: begin
            if (rx_byte == CHAR_O) begin
               state_in = ST_HUNT5;
               sum_in   = sum_add;
            end
         end
         ST_HUNT5: begin
            if (rx_byte == CHAR_V) begin
               state_in = ST_VERSION;
               sum_in   = sum_add;
            end
         end
         ST_VERSION: begin
            if (rx_byte == expected_version) begin
               state_in = ST_TYPE;
               sum_in   = sum_add;
            end
         end
         ST_TYPE: begin
            type_in  = rx_byte;
            sum_in   = sum_add;
            state_in = ST_LENGTH;
         end
         ST_LENGTH: begin
            length_in = rx_byte;
            remain_in = rx_byte;
            sum_in    = sum_add;
            state_in  = (rx_byte == '0) ? ST_CHECK : ST_PAYLOAD;
         end
         ST_PAYLOAD: begin
            res_vld           = 1'b1;
            res.payload_byte  = rx_byte;
            res.payload_index = length_ff - remain_ff;
            sum_in            = sum_add;
            remain_in         = remain_ff - 8'd1;
            state_in          = (remain_ff == 8'd1) ? ST_CHECK : ST_PAYLOAD;
         end
         ST_CHECK: begin
            res_vld         = 1'b1;
            res.is_end      = 1'b1;
            res.checksum_ok = (rx_byte == sum_ff);
            state_in        = ST_HUNT0;
            sum_in          = '0;
            remain_in       = '0;
         end
         default: begin
         end
      endcase
      if (!step) begin
         res_vld = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_HUNT0;
         type_ff   <= '0;
         length_ff <= '0;
         remain_ff <= '0;
         sum_ff    <= '0;
      end else if (step) begin
         state_ff  <= state_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         remain_ff <= remain_in;
         sum_ff    <= sum_in;
      end
   end

   a_result_phase: assert property (@(posedge clock) disable iff (reset)
      res_vld |-> (state_ff == ST_PAYLOAD || state_ff == ST_CHECK))
      else $error("result outside payload or checksum phase");

   a_end_rehunt: assert property (@(posedge clock) disable iff (reset)
      (step && state_ff == ST_CHECK) |=> (state_ff == ST_HUNT0 && sum_ff == '0))
      else $error("hunt not restarted after checksum byte");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (res_vld && !res.is_end) |-> (res.payload_index < res.payload_length))
      else $error("payload index beyond declared length");

endmodule

>>> rtl/core/mfd_out_buf.sv
module mfd_out_buf
   import mfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mfd_result_type push_data,
   output logic           full,
   output logic           out_vld,
   input  logic           out_rdy,
   output mfd_result_type out_data
);

   mfd_result_type mem_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           pop;

   assign full     = (count_ff == 2'd2);
   assign out_vld  = (count_ff != 2'd0);
   assign out_data = mem_ff[rd_ptr_ff];
   assign pop      = out_vld && out_rdy;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("result written into full buffer");

   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd3) && ((count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff)))
      else $error("buffer count and pointers disagree");

endmodule

>>> rtl/core/magic_frame_deframer_top.sv
// data path: a byte taken on req is held in the input register and is processed
// when the result buffer has room; its result, if any, is registered in the
// result buffer before it is offered on rsp
// throughput: one byte per cycle, held up only by rsp_tready (two-entry
// result buffer behind a single input register)
// reset: synchronous active high; hunt restarts empty, expected version = 1
module magic_frame_deframer_top
   import mfd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [ByteWidth-1:0]    csr_wr_data,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ByteWidth-1:0]    req_tdata,  // rx_byte
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,  // frame_type, payload_byte,
                                                // payload_index, payload_length
   output logic                    rsp_tlast,  // is_end
   output logic                    rsp_tuser   // checksum_ok
);

   logic [ByteWidth-1:0] version_ff;
   logic                 in_vld_ff, in_vld_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 step;
   logic                 buf_full;
   logic                 res_vld;
   mfd_result_type       res;
   mfd_result_type       rsp;

   // input register drains whenever the result buffer has room
   assign step       = in_vld_ff && !buf_full;
   assign req_tready = !in_vld_ff || !buf_full;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (step) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
         in_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_wr_en) begin
            version_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   mfd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .rx_byte          (in_byte_ff),
      .expected_version (version_ff),
      .res_vld          (res_vld),
      .res              (res)
   );

   mfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_vld),
      .push_data (res),
      .full      (buf_full),
      .out_vld   (rsp_tvalid),
      .out_rdy   (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {rsp.payload_length, rsp.payload_index,
                       rsp.payload_byte, rsp.frame_type};
   assign rsp_tlast = rsp.is_end;
   assign rsp_tuser = rsp.checksum_ok;

endmodule
